[rtl/b58bd_pkg.sv]
// Shared types, codes and lookup functions for the Base58 block decoder.
`timescale 1ns / 1ps

package b58bd_pkg;

	localparam int unsigned FullChars = 11;
	localparam int unsigned FullBytes = 8;

	typedef enum logic [1:0] {
		ST_DATA     = 2'd0,
		ST_BAD_CHAR = 2'd1,
		ST_OVERFLOW = 2'd2,
		ST_BAD_TAIL = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       last_char;
	} char_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		status_t    status;
		logic       last_of_run;
		logic       end_of_string;
	} result_item_t;

	// One group of results caused by a single character.
	typedef struct packed {
		logic [63:0] value;  // bytes, big-endian; zero for errors
		logic [2:0]  left;   // results remaining after the current one
		status_t     status;
		logic        eos;
	} grp_t;

	typedef struct packed {
		logic       ok;
		logic [5:0] digit;
	} digit_t;

	function automatic digit_t b58_digit(input logic [7:0] c);
		digit_t d;
		d.ok    = 1'b1;
		d.digit = 6'd0;
		case (c) inside
			[8'h31:8'h39]: d.digit = 6'(c - 8'h31);
			[8'h41:8'h48]: d.digit = 6'(c - 8'h41 + 8'd9);
			[8'h4a:8'h4e]: d.digit = 6'(c - 8'h4a + 8'd17);
			[8'h50:8'h5a]: d.digit = 6'(c - 8'h50 + 8'd22);
			[8'h61:8'h6b]: d.digit = 6'(c - 8'h61 + 8'd33);
			[8'h6d:8'h7a]: d.digit = 6'(c - 8'h6d + 8'd44);
			default:       d.ok    = 1'b0;
		endcase
		return d;
	endfunction

	// Bytes produced by a tail of n characters; zero marks a rejected length.
	function automatic logic [3:0] tail_bytes(input logic [3:0] n);
		logic [3:0] b;
		case (n)
			4'd2:    b = 4'd1;
			4'd3:    b = 4'd2;
			4'd5:    b = 4'd3;
			4'd6:    b = 4'd4;
			4'd7:    b = 4'd5;
			4'd9:    b = 4'd6;
			4'd10:   b = 4'd7;
			4'd11:   b = 4'd8;
			default: b = 4'd0;
		endcase
		return b;
	endfunction

endpackage

[rtl/base58_block_decoder_core.sv]
// Top level of the streaming Base58 block decoder.
`timescale 1ns / 1ps

// Base58 block decoder, one character per transaction.
// Input channel char_valid/char_ready/char_data carries a character and a
// flag on the string's last character. Output channel res_valid/res_ready/
// res_data carries one decoded byte or one error code per transaction.
// Every 11 characters give 8 bytes, most significant first; the string's
// tail gives 1 to 7 bytes; any failure gives a single error result, and
// later characters of that string give nothing.
// A character taken is registered in the input stage and decoded there;
// its result group is pushed into the output queue, whose head is offered.
// Throughput: one character per cycle while the decode stage advances; the
// result side moves one byte per cycle while res_ready is high. The decode
// stage holds while a two-group output queue is full, so a long stall of the
// receiver backs up into char_ready after two groups. Characters that cause
// no result pass the decode stage even when the queue is full.
// Reset clears the block accumulator, character count, error flag and
// all valid bits; no result is pending after reset.

module base58_block_decoder_core (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     char_valid,
	output logic                     char_ready,
	input  b58bd_pkg::char_item_t    char_data,
	output logic                     res_valid,
	input  logic                     res_ready,
	output b58bd_pkg::result_item_t  res_data
);
	import b58bd_pkg::*;

	logic       valid_s1;
	char_item_t char_s1;

	logic [63:0] acc_q, acc_n;
	logic        ovf_q, ovf_n;
	logic [3:0]  cib_q, cib_n;
	logic        fail_q, fail_n;

	digit_t      dig;
	logic [70:0] prod;
	logic [63:0] acc_new;
	logic        ovf_new;
	logic [3:0]  cnt;
	logic [3:0]  nbytes;
	logic        has_res;
	grp_t        grp;
	logic        space;
	logic        advance;

	assign advance    = valid_s1 && (!has_res || space);
	assign char_ready = !valid_s1 || advance;

	always_comb begin
		dig     = b58_digit(char_s1.char_code);
		prod    = {7'd0, acc_q} * 71'd58 + {65'd0, dig.digit};
		acc_new = prod[63:0];
		ovf_new = ovf_q || (prod[70:64] != 7'd0);
		cnt     = (cib_q >= 4'(FullChars)) ? 4'(FullChars) : cib_q + 4'd1;
		nbytes  = tail_bytes(cnt);

		acc_n        = 64'd0;
		ovf_n        = 1'b0;
		cib_n        = 4'd0;
		fail_n       = fail_q;
		has_res      = 1'b0;
		grp.value    = 64'd0;
		grp.left     = 3'd0;
		grp.status   = ST_DATA;
		grp.eos      = 1'b1;

		if (fail_q) begin
			if (char_s1.last_char) begin
				fail_n = 1'b0;
			end
		end else if (!dig.ok) begin
			has_res    = 1'b1;
			grp.status = ST_BAD_CHAR;
			fail_n     = !char_s1.last_char;
		end else if (cnt == 4'(FullChars)) begin
			has_res = 1'b1;
			if (ovf_new) begin
				grp.status = ST_OVERFLOW;
				fail_n     = !char_s1.last_char;
			end else begin
				grp.value = acc_new;
				grp.left  = 3'(FullBytes - 1);
				grp.eos   = char_s1.last_char;
			end
		end else if (!char_s1.last_char) begin
			acc_n = acc_new;
			ovf_n = ovf_new;
			cib_n = cnt;
		end else begin
			has_res = 1'b1;
			if (nbytes == 4'd0) begin
				grp.status = ST_BAD_TAIL;
			end else if (ovf_new || ((acc_new >> {nbytes[2:0], 3'b000}) != 64'd0)) begin
				grp.status = ST_OVERFLOW;
			end else begin
				grp.value = acc_new;
				grp.left  = nbytes[2:0] - 3'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			acc_q    <= 64'd0;
			ovf_q    <= 1'b0;
			cib_q    <= 4'd0;
			fail_q   <= 1'b0;
		end else begin
			if (char_ready) begin
				valid_s1 <= char_valid;
			end
			if (advance) begin
				acc_q  <= acc_n;
				ovf_q  <= ovf_n;
				cib_q  <= cib_n;
				fail_q <= fail_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (char_valid && char_ready) begin
			char_s1 <= char_data;
		end
	end

	b58bd_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (advance && has_res),
		.grp       (grp),
		.space     (space),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data)
	);

	a_cib_range: assert property (@(posedge clk) disable iff (!arst_n)
		cib_q <= 4'd10)
		else $error("block character count out of range");
	a_fail_clear: assert property (@(posedge clk) disable iff (!arst_n)
		fail_q |-> cib_q == 4'd0 && !ovf_q && acc_q == 64'd0)
		else $error("block state kept after error");
	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		advance && has_res && grp.status != ST_DATA |->
			grp.left == 3'd0 && grp.eos && grp.value == 64'd0)
		else $error("error group not a single final result");
	a_mid_block: assert property (@(posedge clk) disable iff (!arst_n)
		advance && has_res && grp.status == ST_DATA && !grp.eos |->
			grp.left == 3'(FullBytes - 1))
		else $error("non-final data group is not a full block");

endmodule

[rtl/b58bd_outq.sv]
// Two-entry result group queue that serializes each group into single bytes.
`timescale 1ns / 1ps

module b58bd_outq (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	input  b58bd_pkg::grp_t          grp,
	output logic                     space,
	output logic                     res_valid,
	input  logic                     res_ready,
	output b58bd_pkg::result_item_t  res_data
);
	import b58bd_pkg::*;

	grp_t h0_q, h1_q, h0_n, h1_n;
	logic v0_q, v1_q, v0_n, v1_n;
	logic pop;

	assign space     = !v1_q;
	assign res_valid = v0_q;
	assign pop       = v0_q && res_ready;

	always_comb begin
		res_data.out_byte      = h0_q.value[{h0_q.left, 3'b000} +: 8];
		res_data.status        = h0_q.status;
		res_data.last_of_run   = (h0_q.left == 3'd0);
		res_data.end_of_string = h0_q.eos && (h0_q.left == 3'd0);
	end

	always_comb begin
		h0_n = h0_q;
		h1_n = h1_q;
		v0_n = v0_q;
		v1_n = v1_q;
		if (pop) begin
			if (h0_q.left == 3'd0) begin
				h0_n = h1_q;
				v0_n = v1_q;
				v1_n = 1'b0;
			end else begin
				h0_n.left = h0_q.left - 3'd1;
			end
		end
		if (push) begin
			if (!v0_n) begin
				h0_n = grp;
				v0_n = 1'b1;
			end else begin
				h1_n = grp;
				v1_n = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v0_q <= 1'b0;
			v1_q <= 1'b0;
		end else begin
			v0_q <= v0_n;
			v1_q <= v1_n;
		end
	end

	always_ff @(posedge clk) begin
		h0_q <= h0_n;
		h1_q <= h1_n;
	end

	a_order: assert property (@(posedge clk) disable iff (!arst_n) v1_q |-> v0_q)
		else $error("second entry valid without head");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !v1_q)
		else $error("push into full queue");
	a_partial_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pop && h0_q.left != 3'd0 |=> v0_q && h0_q.left == $past(h0_q.left) - 3'd1)
		else $error("partial pop lost head group");

endmodule
